/* hdl/lmph_pkg.sv */
package lmph_pkg;

  // Default geometry: Q10.8 levels from samples clamped to 0..1023
  localparam int unsigned SAMPLE_MAX_DEF = 1023;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // Port field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned OUT_W       = 18;
  localparam int unsigned REG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  // Largest level the default geometry can show
  localparam logic [OUT_W-1:0] LEVEL_MAX = OUT_W'(SAMPLE_MAX_DEF << FRAC_BITS_DEF);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_METER_DECAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 2'd2;

  // Register reset values (0.9 and 0.99 in Q0.16, 1000 ticks)
  localparam logic [REG_W-1:0] METER_DECAY_RST = 16'd58982;
  localparam logic [REG_W-1:0] PEAK_DECAY_RST  = 16'd64881;
  localparam logic [REG_W-1:0] HOLD_MS_RST     = 16'd1000;

  // Request kind carried on tuser
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
  } func_e;

endpackage

/* hdl/lmph_pole.sv */
module lmph_pole #(
  parameter int unsigned LVL_W = 18
) (
  input  logic [LVL_W-1:0]         z_i,
  input  logic [LVL_W-1:0]         x_i,
  input  logic [lmph_pkg::REG_W-1:0] a_i,
  output logic [LVL_W-1:0]         y_o
);
  import lmph_pkg::*;

  localparam int unsigned SUM_W = LVL_W + REG_W + 2;

  logic [REG_W:0]   b;
  logic [SUM_W-1:0] prod_x;
  logic [SUM_W-1:0] prod_z;
  logic [SUM_W-1:0] sum;

  // One-pole step: (x * (1 - a) + z * a) >> 16, truncated
  assign b      = (REG_W+1)'(1 << REG_W) - {1'b0, a_i};
  assign prod_x = SUM_W'(x_i) * SUM_W'(b);
  assign prod_z = SUM_W'(z_i) * SUM_W'(a_i);
  assign sum    = prod_x + prod_z;
  assign y_o    = sum[REG_W +: LVL_W];

endmodule

/* hdl/level_meter_peak_hold.sv */
// An accepted request goes through the input register, then the result register, to the master side.
// Throughput: one request per clock while the master side does not stall; the state update is
// combinational, in the stage between the input register and the result register.
// Reset (rst_ni low, asynchronous): levels and peaks clear to zero, the hold
// counter sets to all ones (hold expired), registers take their defaults.
module level_meter_peak_hold #(
  parameter int unsigned SAMPLE_MAX = lmph_pkg::SAMPLE_MAX_DEF,
  parameter int unsigned FRAC_BITS  = lmph_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [lmph_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lmph_pkg::REG_W-1:0]         cfg_data_i,
  // Slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lmph_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [15:0] sample
  input  logic                               s_axis_tuser,  // [0] func
  // Master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [17:0] meter_level, [35:18] peak_display, [36] holding, [39:37] zero
  output logic [lmph_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import lmph_pkg::*;

  localparam int unsigned CLAMP_W = $clog2(SAMPLE_MAX + 1);
  localparam int unsigned LVL_W   = CLAMP_W + FRAC_BITS;
  localparam logic [REG_W-1:0] COUNT_MAX = '1;

  // Configuration registers
  logic [REG_W-1:0] meter_decay_q, peak_decay_q, hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_decay_q <= METER_DECAY_RST;
      peak_decay_q  <= PEAK_DECAY_RST;
      hold_ms_q     <= HOLD_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_METER_DECAY: meter_decay_q <= cfg_data_i;
        REG_PEAK_DECAY:  peak_decay_q  <= cfg_data_i;
        REG_HOLD_MS:     hold_ms_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic                in_valid_q;
  func_e               in_func_q;
  logic [SAMPLE_W-1:0] in_sample_q;
  logic                out_valid_q;
  logic                advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q   <= func_e'(s_axis_tuser);
      in_sample_q <= s_axis_tdata[SAMPLE_W-1:0];
    end
  end

  // Meter state
  logic [LVL_W-1:0] level_q, level_d;
  logic [LVL_W-1:0] peak_raw_q, peak_raw_d;
  logic [LVL_W-1:0] peak_smooth_q, peak_smooth_d;
  logic [REG_W-1:0] hold_q, hold_d;

  logic [CLAMP_W-1:0] clamped;
  logic [LVL_W-1:0]   x;
  logic [LVL_W-1:0]   level_filt;
  logic [LVL_W-1:0]   smooth_filt;
  logic               expired_old;
  logic               expired_new;
  logic [LVL_W-1:0]   disp;

  // Clamp the sample to 0..SAMPLE_MAX and scale to fixed point
  always_comb begin
    if (in_sample_q[SAMPLE_W-1]) begin
      clamped = '0;
    end else if ({2'b00, in_sample_q[SAMPLE_W-2:0]} > 17'(SAMPLE_MAX)) begin
      clamped = CLAMP_W'(SAMPLE_MAX);
    end else begin
      clamped = CLAMP_W'(in_sample_q[SAMPLE_W-2:0]);
    end
  end

  assign x = LVL_W'(clamped) << FRAC_BITS;

  lmph_pole #(.LVL_W(LVL_W)) u_meter_pole (
    .z_i (level_q),
    .x_i (x),
    .a_i (meter_decay_q),
    .y_o (level_filt)
  );

  lmph_pole #(.LVL_W(LVL_W)) u_peak_pole (
    .z_i (peak_smooth_q),
    .x_i (x),
    .a_i (peak_decay_q),
    .y_o (smooth_filt)
  );

  assign expired_old = hold_q >= hold_ms_q;

  // Next state for one request
  always_comb begin
    level_d       = level_q;
    peak_raw_d    = peak_raw_q;
    peak_smooth_d = peak_smooth_q;
    hold_d        = hold_q;
    case (in_func_q)
      FUNC_SAMPLE: begin
        level_d = (x > level_q) ? x : level_filt;
        if (x > peak_raw_q) begin
          peak_raw_d    = x;
          peak_smooth_d = x;
          hold_d        = '0;
        end else if (expired_old) begin
          peak_raw_d    = x;
          peak_smooth_d = smooth_filt;
        end
      end
      FUNC_TICK: begin
        if (hold_q != COUNT_MAX) begin
          hold_d = hold_q + REG_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Displayed peak after the update
  assign expired_new = hold_d >= hold_ms_q;
  assign disp = (expired_new && (peak_smooth_d > peak_raw_d)) ? peak_smooth_d : peak_raw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= '0;
      peak_raw_q    <= '0;
      peak_smooth_q <= '0;
      hold_q        <= COUNT_MAX;
    end else if (advance) begin
      level_q       <= level_d;
      peak_raw_q    <= peak_raw_d;
      peak_smooth_q <= peak_smooth_d;
      hold_q        <= hold_d;
    end
  end

  // Result register
  logic [OUT_W-1:0] out_level_q, out_peak_q;
  logic             out_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_level_q <= OUT_W'(level_d);
      out_peak_q  <= OUT_W'(disp);
      out_hold_q  <= !expired_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_hold_q, out_peak_q, out_level_q};

endmodule

/* hdl/lmph_checker.sv */
module lmph_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lmph_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import lmph_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // Meter level stays within the clamped range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:0] <= LEVEL_MAX))
    else $error("meter level out of range");

  // Displayed peak stays within the clamped range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2*OUT_W-1:OUT_W] <= LEVEL_MAX))
    else $error("peak display out of range");

  // Padding bits are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:2*OUT_W+1] == '0))
    else $error("padding bits set");

endmodule

bind level_meter_peak_hold lmph_checker u_lmph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import lmph_pkg::*;

  localparam int unsigned LATENCY        = 2;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS    = 10;

  // Index beyond the register file, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [REG_W-1:0]    REG_ALL_ONES = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] SMP_NEG_MIN  = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SMP_NEG_ONE  = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] SMP_POS_MAX  = 16'h7FFF;

  typedef struct packed {
    func_e                func;
    logic [SAMPLE_W-1:0]  sample;
  } band_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] level;
    logic [OUT_W-1:0] peak;
    logic             holding;
  } meter_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [REG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] sample
  logic                   s_axis_tuser  = 1'b0; // [0] func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [17:0] meter_level, [35:18] peak_display, [36] holding, [39:37] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  level_meter_peak_hold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Meter state and register copies, as after reset
  logic [REG_W-1:0] meter_pole  = METER_DECAY_RST;
  logic [REG_W-1:0] peak_pole   = PEAK_DECAY_RST;
  logic [REG_W-1:0] hold_len    = HOLD_MS_RST;
  logic [OUT_W-1:0] lvl_q       = '0;
  logic [OUT_W-1:0] pk_raw_q    = '0;
  logic [OUT_W-1:0] pk_smooth_q = '0;
  logic [REG_W-1:0] hold_cnt_q  = '1;

  band_req_t     pending_reqs[$];
  meter_result_t expected_readings[$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;
  logic        rx_hold_go   = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned report_cnt   = 0;

  // One-pole step in Q0.16, truncated
  function automatic logic [OUT_W-1:0] one_pole(logic [OUT_W-1:0] z, logic [OUT_W-1:0] x,
                                               logic [REG_W-1:0] a);
    logic [63:0] acc;
    acc = 64'(x) * (64'd65536 - 64'(a)) + 64'(z) * 64'(a);
    return acc[OUT_W+15:16];
  endfunction

  // Advance the meter by one request and return the reading it shows
  function automatic meter_result_t advance_meter(band_req_t req);
    logic [SAMPLE_W-1:0] s;
    logic [OUT_W-1:0]    x;
    logic                expired;
    meter_result_t       res;
    if (req.func == FUNC_SAMPLE) begin
      if (req.sample[SAMPLE_W-1]) begin
        s = '0;
      end else if (req.sample > SAMPLE_W'(SAMPLE_MAX_DEF)) begin
        s = SAMPLE_W'(SAMPLE_MAX_DEF);
      end else begin
        s = req.sample;
      end
      x = OUT_W'(s) << FRAC_BITS_DEF;
      if (x > lvl_q) begin
        lvl_q = x;
      end else begin
        lvl_q = one_pole(lvl_q, x, meter_pole);
      end
      if (x > pk_raw_q) begin
        pk_raw_q    = x;
        pk_smooth_q = x;
        hold_cnt_q  = '0;
      end else if (hold_cnt_q >= hold_len) begin
        pk_raw_q    = x;
        pk_smooth_q = one_pole(pk_smooth_q, x, peak_pole);
      end
    end else if (hold_cnt_q != '1) begin
      hold_cnt_q = hold_cnt_q + 1'b1;
    end
    expired     = hold_cnt_q >= hold_len;
    res.level   = lvl_q;
    res.peak    = (expired && pk_smooth_q > pk_raw_q) ? pk_smooth_q : pk_raw_q;
    res.holding = !expired;
    return res;
  endfunction

  // Driver: predict on acceptance, then offer the next request or idle
  always @(posedge clk_i) begin : drive_requests
    band_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.func   = func_e'(s_axis_tuser);
        req.sample = s_axis_tdata;
        expected_readings.push_back(advance_meter(req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.sample;
          s_axis_tuser  <= req.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down on its own
  always @(posedge clk_i) begin
    if (rx_hold_go) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Monitor: compare each reading with the oldest expectation
  always @(posedge clk_i) begin : check_readings
    meter_result_t got;
    meter_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.level   = m_axis_tdata[OUT_W-1:0];
        got.peak    = m_axis_tdata[2*OUT_W-1:OUT_W];
        got.holding = m_axis_tdata[2*OUT_W];
        if (expected_readings.size() == 0) begin
          mismatch_cnt++;
          if (report_cnt < MAX_REPORTS) begin
            report_cnt++;
            $display("%0t: unexpected reading level %h peak %h holding %b",
                     $realtime, got.level, got.peak, got.holding);
          end
        end else begin
          want = expected_readings.pop_front();
          if (got.level !== want.level || got.peak !== want.peak ||
              got.holding !== want.holding) begin
            mismatch_cnt++;
            if (report_cnt < MAX_REPORTS) begin
              report_cnt++;
              $display("%0t: reading mismatch, expected level %h peak %h holding %b",
                       $realtime, want.level, want.peak, want.holding);
              $display("%0t:                     got level %h peak %h holding %b",
                       $realtime, got.level, got.peak, got.holding);
            end
          end
        end
      end
      m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Write one register and mirror it in the meter copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    unique case (idx)
      REG_METER_DECAY: meter_pole = val;
      REG_PEAK_DECAY:  peak_pole  = val;
      REG_HOLD_MS:     hold_len   = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [REG_W-1:0] m, input logic [REG_W-1:0] p,
                           input logic [REG_W-1:0] h);
    write_reg(REG_METER_DECAY, m);
    write_reg(REG_PEAK_DECAY, p);
    write_reg(REG_HOLD_MS, h);
  endtask

  // Hold until every request is sent and every reading has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_readings.size() != 0);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic push_req(input func_e f, input logic [SAMPLE_W-1:0] smp);
    band_req_t req;
    req.func   = f;
    req.sample = smp;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return SAMPLE_W'($urandom_range(SAMPLE_MAX_DEF));
      6:                return SAMPLE_W'($urandom_range(32767, SAMPLE_MAX_DEF + 1));
      7:                return SMP_NEG_MIN | SAMPLE_W'($urandom);
      8: begin
        case ($urandom_range(5))
          0:       return '0;
          1:       return SAMPLE_W'(SAMPLE_MAX_DEF);
          2:       return SAMPLE_W'(SAMPLE_MAX_DEF + 1);
          3:       return SMP_POS_MAX;
          4:       return SMP_NEG_MIN;
          default: return SMP_NEG_ONE;
        endcase
      end
      default:          return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Mostly runs of a fresh peak followed by lower samples and ticks,
  // the rest loose noise
  task automatic push_random(input int n, input int tick_pct);
    int left;
    int top;
    int run;
    left = n;
    while (left > 0) begin
      if ($urandom_range(9) < 7) begin
        top = $urandom_range(SAMPLE_MAX_DEF);
        run = $urandom_range(40, 4);
        push_req(FUNC_SAMPLE, SAMPLE_W'(top));
        left--;
        for (int k = 0; k < run && left > 0; k++) begin
          if ($urandom_range(99) < tick_pct) begin
            push_req(FUNC_TICK, SAMPLE_W'($urandom));
          end else if ($urandom_range(9) == 0) begin
            push_req(FUNC_SAMPLE, rand_sample());
          end else begin
            push_req(FUNC_SAMPLE, SAMPLE_W'($urandom_range(top)));
          end
          left--;
        end
      end else begin
        push_req($urandom_range(1) ? FUNC_TICK : FUNC_SAMPLE, rand_sample());
        left--;
      end
    end
  endtask

  task automatic run_phase(input logic [REG_W-1:0] m, input logic [REG_W-1:0] p,
                           input logic [REG_W-1:0] h, input int unsigned tx,
                           input int unsigned rx, input int n, input int tick_pct,
                           input bit long_hold);
    wait_drained();
    configure(m, p, h);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    push_random(n, tick_pct);
    // Hold off the receiver while requests keep coming, so the block backs up
    if (long_hold) begin
      @(posedge clk_i);
      rx_hold_go <= 1'b1;
      @(posedge clk_i);
      rx_hold_go <= 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Saturated counter against the longest hold: still counts as expired
    write_reg(REG_HOLD_MS, REG_ALL_ONES);
    push_req(FUNC_TICK, '0);
    push_req(FUNC_SAMPLE, '0);
    wait_drained();
    write_reg(REG_HOLD_MS, HOLD_MS_RST);

    // Reset defaults: clamping at both ends, ticks while a fresh peak is held
    push_req(FUNC_SAMPLE, '0);
    push_req(FUNC_SAMPLE, SMP_NEG_MIN);
    push_req(FUNC_SAMPLE, SMP_NEG_ONE);
    push_req(FUNC_SAMPLE, SAMPLE_W'(SAMPLE_MAX_DEF));
    push_req(FUNC_TICK, SMP_NEG_ONE);
    push_req(FUNC_SAMPLE, SAMPLE_W'(SAMPLE_MAX_DEF + 1));
    push_req(FUNC_SAMPLE, SMP_POS_MAX);
    push_req(FUNC_SAMPLE, SAMPLE_W'(512));
    push_req(FUNC_TICK, '0);
    push_req(FUNC_TICK, SMP_POS_MAX);
    wait_drained();

    // Zero hold and zero poles: peak follows at once, filters pass straight through
    configure('0, '0, '0);
    push_req(FUNC_SAMPLE, SAMPLE_W'(SAMPLE_MAX_DEF));
    push_req(FUNC_SAMPLE, SAMPLE_W'(100));
    push_req(FUNC_TICK, '0);
    push_req(FUNC_SAMPLE, '0);
    push_req(FUNC_SAMPLE, SAMPLE_W'(SAMPLE_MAX_DEF));
    push_req(FUNC_SAMPLE, SAMPLE_W'(1));
    wait_drained();

    // Short hold that expires by ticks; the stray write must change nothing
    configure(METER_DECAY_RST, PEAK_DECAY_RST, 16'd3);
    write_reg(REG_UNUSED, '0);
    push_req(FUNC_SAMPLE, SAMPLE_W'(800));
    push_req(FUNC_TICK, '0);
    push_req(FUNC_SAMPLE, SAMPLE_W'(10));
    push_req(FUNC_TICK, '0);
    push_req(FUNC_TICK, '0);
    push_req(FUNC_TICK, '0);
    push_req(FUNC_SAMPLE, SAMPLE_W'(10));
    push_req(FUNC_SAMPLE, SAMPLE_W'(5));

    // Random phases across settings and idling patterns
    run_phase(METER_DECAY_RST, PEAK_DECAY_RST, 16'd8, 0, 0, 220, 30, 1'b0);
    run_phase('0, '0, '0, 64, 0, 220, 30, 1'b0);
    run_phase(REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, 0, 64, 220, 30, 1'b0);
    run_phase(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom_range(40, 1)),
              38, 38, 220, 35, 1'b0);
    run_phase(16'h8000, REG_ALL_ONES, 16'd1, 0, 0, 220, 25, 1'b1);
    run_phase(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom_range(15)),
              64, 0, 220, 30, 1'b0);
    run_phase(REG_ALL_ONES, '0, 16'd20, 38, 38, 220, 40, 1'b0);
    wait_drained();

    repeat (4 * LATENCY) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/lmph_pkg.sv
hdl/lmph_pole.sv
hdl/level_meter_peak_hold.sv
hdl/lmph_checker.sv
tb/tb.sv
